// ===== hw/rtl/ggce_pkg.sv =====
// shared types, constants and the character table of the grid code encoder
package ggce_pkg;

    // input field widths
    localparam int LAT_WHOLE_W = 7;
    localparam int LON_WHOLE_W = 8;
    localparam int FRAC_W      = 17;

    // datapath widths
    localparam int LAT_VAL_W = 8;   // 2*whole+negative, up to 179
    localparam int LON_VAL_W = 9;   // 2*whole+negative, up to 359
    localparam int SUM_W     = 10;  // up to 538
    localparam int COMB_W    = 16;  // combination number, up to 64800
    localparam int ACC_W     = 50;  // point number before the offset
    localparam int OFFSET_W  = 53;
    localparam int VALUE_W   = 54;  // point number plus offset
    localparam int HALF_W    = 27;  // one chunk of the long division by 27
    localparam int CHUNK_W   = 32;  // remainder:chunk
    localparam int REM_W     = 5;
    localparam int DIGIT_W   = 5;
    localparam int DEC_W     = 4;
    localparam int CHAR_W    = 7;

    // base-27 digit store
    localparam int DIGIT_DEPTH = 12;
    localparam int CNT_W       = 4;

    // saturation limits
    localparam logic [LAT_WHOLE_W-1:0] LAT_WHOLE_MAX = 7'd89;
    localparam logic [LON_WHOLE_W-1:0] LON_WHOLE_MAX = 8'd179;
    localparam logic [FRAC_W-1:0]      FRAC_MAX      = 17'd99999;

    // band limits and bases of the combination number
    localparam logic [SUM_W-1:0]  BAND1_START = 10'd180;
    localparam logic [SUM_W-1:0]  BAND2_START = 10'd360;
    localparam logic [SUM_W-1:0]  BAND2_TOP   = 10'd719;
    localparam logic [SUM_W-1:0]  BAND_WIDTH  = 10'd180;
    localparam logic [COMB_W-1:0] BAND1_BASE  = 16'd16290 + 16'd180;
    localparam logic [COMB_W-1:0] BAND2_BASE  = 16'd48690 + 16'd180;

    // reciprocal of 10 for 17-bit fractions: q = (f * RECIP10) >> RECIP10_SHIFT
    localparam int RECIP10_W     = 18;
    localparam logic [RECIP10_W-1:0] RECIP10 = 18'd209716;
    localparam int RECIP10_SHIFT = 21;

    // reciprocal of 27 for 32-bit chunks: q = (c * RECIP27) >> RECIP27_SHIFT
    localparam int RECIP27_W     = 33;
    localparam logic [RECIP27_W-1:0] RECIP27 = 33'd5090331611;
    localparam int RECIP27_SHIFT = 37;
    localparam int PROD27_W      = CHUNK_W + RECIP27_W;

    // register indexes of the configuration port
    localparam logic CFG_POINT_OFFSET = 1'b0;
    localparam logic CFG_FORMATTED    = 1'b1;

    // reset values of the registers
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 53'd205891132094649;

    // separators
    localparam logic [CHAR_W-1:0] CHAR_HASH = 7'd35;
    localparam logic [CHAR_W-1:0] CHAR_DASH = 7'd45;

    // request to the radix unit
    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] value;
    } radix_ctl_t;

    // status of the radix unit
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
    } radix_stat_t;

    // base-27 digit to its ASCII symbol
    function automatic logic [CHAR_W-1:0] ggce_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        case (d)
            5'd0:    c = 7'd48;
            5'd1:    c = 7'd49;
            5'd2:    c = 7'd50;
            5'd3:    c = 7'd51;
            5'd4:    c = 7'd52;
            5'd5:    c = 7'd53;
            5'd6:    c = 7'd54;
            5'd7:    c = 7'd55;
            5'd8:    c = 7'd56;
            5'd9:    c = 7'd57;
            5'd10:   c = 7'd67;  // C
            5'd11:   c = 7'd68;  // D
            5'd12:   c = 7'd70;  // F
            5'd13:   c = 7'd71;  // G
            5'd14:   c = 7'd72;  // H
            5'd15:   c = 7'd74;  // J
            5'd16:   c = 7'd75;  // K
            5'd17:   c = 7'd76;  // L
            5'd18:   c = 7'd77;  // M
            5'd19:   c = 7'd78;  // N
            5'd20:   c = 7'd80;  // P
            5'd21:   c = 7'd82;  // R
            5'd22:   c = 7'd84;  // T
            5'd23:   c = 7'd86;  // V
            5'd24:   c = 7'd87;  // W
            5'd25:   c = 7'd88;  // X
            5'd26:   c = 7'd89;  // Y
            default: c = 7'd48;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/geo_grid_code_encoder.sv =====
// top level of the grid code encoder: sequencer, point number datapath and character output
//
// usage
//   one coordinate pair is a command transaction: it is taken at a rising edge with
//   start high and busy low, and busy stays high until the code has been sent
//   the code leaves one character per cycle on code_char with char_valid high for
//   exactly one cycle; last_char marks the final character of the code
//   the receiver cannot stall, every strobed character is taken
//   point_offset (index 0) and formatted_output (index 1) are written through
//   cfg_write/cfg_index/cfg_data; the user must write them only while busy is low,
//   which the block itself does not enforce
// processing steps
//   the sequencer forms the combination number, extracts five fraction digits per
//   axis, builds the point number and adds the offset; the base-27 unit then runs
//   R_MUL_HI, R_FIX_HI, R_MUL_LO and R_FIX_LO for each code digit (L digits, 1..12),
//   and the characters follow at one per cycle (C of them, up to 14); the next pair
//   can be taken at the edge that takes the last character
// reset
//   rst_n clears the sequencer and the strobe, point_offset returns to its default
//   and formatted output is selected
module geo_grid_code_encoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                lat_negative,
    input  logic [ggce_pkg::LAT_WHOLE_W-1:0]    lat_whole,
    input  logic [ggce_pkg::FRAC_W-1:0]         lat_fraction,
    input  logic                                lon_negative,
    input  logic [ggce_pkg::LON_WHOLE_W-1:0]    lon_whole,
    input  logic [ggce_pkg::FRAC_W-1:0]         lon_fraction,
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [ggce_pkg::OFFSET_W-1:0]       cfg_data,
    output logic                                char_valid,
    output logic [ggce_pkg::CHAR_W-1:0]         code_char,
    output logic                                last_char
);
    import ggce_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_COMB_MUL = 3'd1;
    localparam logic [2:0] ST_COMB_ADD = 3'd2;
    localparam logic [2:0] ST_FRAC     = 3'd3;
    localparam logic [2:0] ST_HORNER   = 3'd4;
    localparam logic [2:0] ST_OFFSET   = 3'd5;
    localparam logic [2:0] ST_RADIX    = 3'd6;
    localparam logic [2:0] ST_EMIT     = 3'd7;

    localparam int DIG_PAIRS = 5;
    localparam int DIGS_W    = 2 * DIG_PAIRS * DEC_W;
    localparam int MUL_W     = 17;
    localparam int PROD10_W  = FRAC_W + RECIP10_W;
    localparam int FMT_CHARS = 11;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [3:0]       step_reg, step_next;
    logic [CNT_W-1:0] emit_reg, emit_next;
    logic             hash_reg, hash_next;
    logic             dash_reg, dash_next;
    logic             valid_reg, valid_next;

    // configuration registers
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic                fmt_reg, fmt_next;

    // payload
    logic [LAT_VAL_W-1:0] lat_val_reg, lat_val_next;
    logic [LON_VAL_W-1:0] lon_val_reg, lon_val_next;
    logic [FRAC_W-1:0]    lat_frac_reg, lat_frac_next;
    logic [FRAC_W-1:0]    lon_frac_reg, lon_frac_next;
    logic [MUL_W-1:0]     band_prod_reg, band_prod_next;
    logic [COMB_W-1:0]    band_add_reg, band_add_next;
    logic                 band_half_reg, band_half_next;
    logic [DIGS_W-1:0]    digs_reg, digs_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;

    // band selection
    logic [SUM_W-1:0]     wsum;
    logic [7:0]           mul_x;
    logic [8:0]           mul_y;
    logic [COMB_W-1:0]    comb;

    // fraction digit lanes
    logic [PROD10_W-1:0]  lat_p10, lon_p10;
    logic [FRAC_W-1:0]    lat_q10, lon_q10;
    logic [DEC_W-1:0]     lat_dec, lon_dec;

    // radix unit
    radix_ctl_t           radix_ctl;
    radix_stat_t          radix_stat;
    logic [CNT_W-1:0]     rd_index;
    logic [DIGIT_W-1:0]   rd_digit;
    logic [CNT_W-1:0]     n_chars;
    logic [CNT_W-1:0]     emit_inc;
    logic                 dash_after;

    ggce_radix u_radix (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (radix_ctl),
        .stat     (radix_stat),
        .rd_index (rd_index),
        .rd_digit (rd_digit)
    );

    // configuration port
    always_comb
    begin
        offset_next = offset_reg;
        fmt_next    = fmt_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_POINT_OFFSET: offset_next = cfg_data;
                CFG_FORMATTED:    fmt_next    = cfg_data[0];
            endcase
        end
    end

    // band operands: triangular, linear or falling triangular in the sum of the axis values
    always_comb
    begin
        wsum = SUM_W'(lon_val_reg) + SUM_W'(lat_val_reg);
        priority if (wsum < BAND1_START)
        begin
            mul_x          = 8'(wsum);
            mul_y          = 9'(wsum + SUM_W'(1));
            band_half_next = 1'b1;
            band_add_next  = COMB_W'(lon_val_reg) + COMB_W'(1);
        end
        else if (wsum < BAND2_START)
        begin
            mul_x          = 8'(wsum - BAND1_START);
            mul_y          = 9'(BAND_WIDTH);
            band_half_next = 1'b0;
            band_add_next  = BAND1_BASE - COMB_W'(lat_val_reg);
        end
        else
        begin
            mul_x          = 8'(wsum - BAND2_START);
            mul_y          = 9'(BAND2_TOP - wsum);
            band_half_next = 1'b1;
            band_add_next  = BAND2_BASE - COMB_W'(lat_val_reg);
        end
        band_prod_next = MUL_W'(mul_x) * MUL_W'(mul_y);
        comb = (band_half_reg ? COMB_W'(band_prod_reg >> 1) : COMB_W'(band_prod_reg))
               + band_add_reg;
    end

    // one decimal digit per axis per step, least significant first
    always_comb
    begin
        lat_p10 = PROD10_W'(lat_frac_reg) * PROD10_W'(RECIP10);
        lon_p10 = PROD10_W'(lon_frac_reg) * PROD10_W'(RECIP10);
        lat_q10 = FRAC_W'(lat_p10 >> RECIP10_SHIFT);
        lon_q10 = FRAC_W'(lon_p10 >> RECIP10_SHIFT);
        lat_dec = DEC_W'(lat_frac_reg - FRAC_W'(lat_q10 * FRAC_W'(10)));
        lon_dec = DEC_W'(lon_frac_reg - FRAC_W'(lon_q10 * FRAC_W'(10)));
    end

    // formatted codes keep at most eleven digit symbols
    assign n_chars  = (fmt_reg && radix_stat.count > CNT_W'(FMT_CHARS))
                      ? CNT_W'(FMT_CHARS) : radix_stat.count;
    assign emit_inc = emit_reg + CNT_W'(1);
    // digit read is registered: address the digit of the next emit position
    assign rd_index = radix_stat.count - emit_next - CNT_W'(1);
    // dash after the fourth and the eighth digit
    assign dash_after = fmt_reg && (emit_inc == CNT_W'(4) || emit_inc == CNT_W'(8));

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        emit_next       = emit_reg;
        hash_next       = hash_reg;
        dash_next       = dash_reg;
        valid_next      = 1'b0;
        lat_val_next    = lat_val_reg;
        lon_val_next    = lon_val_reg;
        lat_frac_next   = lat_frac_reg;
        lon_frac_next   = lon_frac_reg;
        digs_next       = digs_reg;
        acc_next        = acc_reg;
        char_next       = char_reg;
        last_next       = last_reg;
        radix_ctl.start = 1'b0;
        radix_ctl.value = VALUE_W'(acc_reg) + VALUE_W'(offset_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // saturate out-of-range fields
                    lat_val_next = {(lat_whole > LAT_WHOLE_MAX) ? LAT_WHOLE_MAX : lat_whole,
                                    lat_negative};
                    lon_val_next = {(lon_whole > LON_WHOLE_MAX) ? LON_WHOLE_MAX : lon_whole,
                                    lon_negative};
                    lat_frac_next = (lat_fraction > FRAC_MAX) ? FRAC_MAX : lat_fraction;
                    lon_frac_next = (lon_fraction > FRAC_MAX) ? FRAC_MAX : lon_fraction;
                    state_next    = ST_COMB_MUL;
                end
            end
            ST_COMB_MUL:
            begin
                state_next = ST_COMB_ADD;
            end
            ST_COMB_ADD:
            begin
                acc_next   = ACC_W'(comb);
                step_next  = '0;
                state_next = ST_FRAC;
            end
            ST_FRAC:
            begin
                lat_frac_next = lat_q10;
                lon_frac_next = lon_q10;
                digs_next     = {lon_dec, lat_dec, digs_reg[DIGS_W-1:2*DEC_W]};
                step_next     = step_reg + 4'd1;
                if (step_reg == 4'(DIG_PAIRS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_HORNER;
                end
            end
            ST_HORNER:
            begin
                // acc*10 + next digit, longitude digit first
                acc_next  = ACC_W'({acc_reg, 3'b000}) + ACC_W'({acc_reg, 1'b0})
                            + ACC_W'(digs_reg[DIGS_W-1:DIGS_W-DEC_W]);
                digs_next = {digs_reg[DIGS_W-DEC_W-1:0], {DEC_W{1'b0}}};
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(2 * DIG_PAIRS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_OFFSET;
                end
            end
            ST_OFFSET:
            begin
                radix_ctl.start = 1'b1;
                state_next      = ST_RADIX;
            end
            ST_RADIX:
            begin
                if (radix_stat.done)
                begin
                    emit_next  = '0;
                    hash_next  = fmt_reg;
                    dash_next  = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                valid_next = 1'b1;
                priority if (hash_reg)
                begin
                    char_next = CHAR_HASH;
                    last_next = 1'b0;
                    hash_next = 1'b0;
                end
                else if (dash_reg)
                begin
                    char_next = CHAR_DASH;
                    last_next = (emit_reg == n_chars);
                    dash_next = 1'b0;
                end
                else
                begin
                    char_next = ggce_char(rd_digit);
                    emit_next = emit_inc;
                    last_next = (emit_inc == n_chars) && !dash_after;
                    dash_next = dash_after;
                end
                if (last_next)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            emit_reg   <= '0;
            hash_reg   <= 1'b0;
            dash_reg   <= 1'b0;
            valid_reg  <= 1'b0;
            offset_reg <= OFFSET_RESET;
            fmt_reg    <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            emit_reg   <= emit_next;
            hash_reg   <= hash_next;
            dash_reg   <= dash_next;
            valid_reg  <= valid_next;
            offset_reg <= offset_next;
            fmt_reg    <= fmt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lat_val_reg   <= lat_val_next;
        lon_val_reg   <= lon_val_next;
        lat_frac_reg  <= lat_frac_next;
        lon_frac_reg  <= lon_frac_next;
        band_prod_reg <= band_prod_next;
        band_add_reg  <= band_add_next;
        band_half_reg <= band_half_next;
        digs_reg      <= digs_next;
        acc_reg       <= acc_next;
        char_reg      <= char_next;
        last_reg      <= last_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign char_valid = valid_reg;
    assign code_char  = char_reg;
    assign last_char  = last_reg;

endmodule

// ===== hw/rtl/ggce_radix.sv =====
// iterative base-27 converter: one shared reciprocal multiplier, two chunks per digit
module ggce_radix (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ggce_pkg::radix_ctl_t                ctl,
    output ggce_pkg::radix_stat_t               stat,
    input  logic [ggce_pkg::CNT_W-1:0]          rd_index,
    output logic [ggce_pkg::DIGIT_W-1:0]        rd_digit
);
    import ggce_pkg::*;

    localparam logic [2:0] R_IDLE   = 3'd0;
    localparam logic [2:0] R_MUL_HI = 3'd1;
    localparam logic [2:0] R_FIX_HI = 3'd2;
    localparam logic [2:0] R_MUL_LO = 3'd3;
    localparam logic [2:0] R_FIX_LO = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                done_reg, done_next;

    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [HALF_W-1:0]   qhi_reg, qhi_next;
    logic [CHUNK_W-1:0]  chunk_reg, chunk_next;
    logic [PROD27_W-1:0] prod_reg, prod_next;
    logic [DIGIT_W-1:0]  digits_reg [DIGIT_DEPTH];
    logic [DIGIT_W-1:0]  rd_digit_reg;

    logic [PROD27_W-RECIP27_SHIFT-1:0] quot;
    logic [REM_W-1:0]                  rem_fix;
    logic                              wr_en;

    // shared unit: chunk times reciprocal, then quotient and remainder
    always_comb
    begin
        chunk_next = chunk_reg;
        if (state_reg == R_MUL_HI)
        begin
            chunk_next = {{REM_W{1'b0}}, val_reg[VALUE_W-1:HALF_W]};
        end
        else if (state_reg == R_MUL_LO)
        begin
            chunk_next = {rem_reg, val_reg[HALF_W-1:0]};
        end
        prod_next = PROD27_W'(chunk_next) * PROD27_W'(RECIP27);
        quot      = prod_reg[PROD27_W-1:RECIP27_SHIFT];
        rem_fix   = REM_W'(chunk_reg - CHUNK_W'(CHUNK_W'(quot) * CHUNK_W'(27)));
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        val_next   = val_reg;
        rem_next   = rem_reg;
        qhi_next   = qhi_reg;
        wr_en      = 1'b0;
        unique case (state_reg)
            R_IDLE:
            begin
                if (ctl.start)
                begin
                    val_next   = ctl.value;
                    count_next = '0;
                    state_next = R_MUL_HI;
                end
            end
            R_MUL_HI:
            begin
                state_next = R_FIX_HI;
            end
            R_FIX_HI:
            begin
                qhi_next   = HALF_W'(quot);
                rem_next   = rem_fix;
                state_next = R_MUL_LO;
            end
            R_MUL_LO:
            begin
                state_next = R_FIX_LO;
            end
            R_FIX_LO:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
                val_next   = {qhi_reg, HALF_W'(quot)};
                if (val_next == '0)
                begin
                    done_next  = 1'b1;
                    state_next = R_IDLE;
                end
                else
                begin
                    state_next = R_MUL_HI;
                end
            end
            default:
            begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // digits are stored least significant first; the read data is registered,
    // so rd_digit holds the digit that rd_index addressed in the cycle before
    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        rem_reg   <= rem_next;
        qhi_reg   <= qhi_next;
        chunk_reg <= chunk_next;
        prod_reg  <= prod_next;
        if (wr_en)
        begin
            digits_reg[count_reg] <= rem_fix;
        end
        rd_digit_reg <= (rd_index < CNT_W'(DIGIT_DEPTH)) ? digits_reg[rd_index] : '0;
    end

    assign rd_digit   = rd_digit_reg;
    assign stat.done  = done_reg;
    assign stat.count = count_reg;

endmodule

// ===== hw/rtl/ggce_checker.sv =====
// port-level checks of the grid code encoder and their bind
module ggce_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       char_valid,
    input logic       last_char
);

    // a character that is not the last one comes while the transaction is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !last_char |-> busy)
        else $error("non-final character outside a running transaction");

    // the last character closes the transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && last_char |-> !busy)
        else $error("busy still high with the final character");

    // an accepted pair makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // no character appears out of idle without a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !start |=> !char_valid)
        else $error("character strobe without a transaction");

endmodule

bind geo_grid_code_encoder ggce_checker u_ggce_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .char_valid (char_valid),
    .last_char  (last_char)
);

// ===== tb/tb_geo_grid_code_encoder.sv =====
// self-checking testbench of the grid code encoder: command driver, character monitor, predictor
module tb_geo_grid_code_encoder;

    timeunit 1ns;
    timeprecision 1ps;

    import ggce_pkg::*;

    // no transaction and no character for this many cycles means the block hung;
    // the slowest pair with the longest sender gap stays well below it
    localparam int WATCHDOG_LIMIT = 2000;
    // cycles to watch after the last expected character for stray strobes
    localparam int TAIL_CYCLES = 100;
    // cycles let pass after the last character before a register write
    localparam int SETTLE_CYCLES = 4;

    // symbols of the base-27 digits, digit 0 in the top byte
    localparam logic [8*27-1:0] GRID_DIGITS = "0123456789CDFGHJKLMNPRTVWXY";

    typedef struct {
        logic                   lat_negative;
        logic [LAT_WHOLE_W-1:0] lat_whole;
        logic [FRAC_W-1:0]      lat_fraction;
        logic                   lon_negative;
        logic [LON_WHOLE_W-1:0] lon_whole;
        logic [FRAC_W-1:0]      lon_fraction;
    } coord_pair_t;

    typedef struct {
        logic [CHAR_W-1:0] code_char;
        logic              last_char;
    } grid_char_t;

    // every input starts at a known value; the driver and the register task own them after that
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   lat_negative = 1'b0;
    logic [LAT_WHOLE_W-1:0] lat_whole = '0;
    logic [FRAC_W-1:0]      lat_fraction = '0;
    logic                   lon_negative = 1'b0;
    logic [LON_WHOLE_W-1:0] lon_whole = '0;
    logic [FRAC_W-1:0]      lon_fraction = '0;
    logic                   cfg_write = 1'b0;
    logic                   cfg_index = CFG_POINT_OFFSET;
    logic [OFFSET_W-1:0]    cfg_data = '0;
    logic                   char_valid;
    logic [CHAR_W-1:0]      code_char;
    logic                   last_char;

    // pairs waiting for the driver and characters waiting for the block
    coord_pair_t pending_pairs[$];
    grid_char_t  expected_chars[$];

    // register copies of the predictor
    logic [OFFSET_W-1:0] offset_copy;
    logic                formatted_copy;

    logic took_pair = 1'b0;     // a pair was taken at the last rising edge
    logic sender_idles = 1'b1;  // random gaps between pairs allowed
    int   gap_left = 0;
    int   quiet_cycles = 0;
    int   fail_count = 0;
    int   pairs_taken = 0;
    int   chars_checked = 0;
    int   settings_run = 0;

    geo_grid_code_encoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .lat_negative (lat_negative),
        .lat_whole    (lat_whole),
        .lat_fraction (lat_fraction),
        .lon_negative (lon_negative),
        .lon_whole    (lon_whole),
        .lon_fraction (lon_fraction),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .char_valid   (char_valid),
        .code_char    (code_char),
        .last_char    (last_char)
    );

    always #5 clk = ~clk;

    // combination number of the two axis values, three bands of their sum
    function automatic int unsigned pair_combination(input int unsigned lon_v,
                                                     input int unsigned lat_v);
        int unsigned s;
        int unsigned n;
        s = lon_v + lat_v;
        n = (s > 360) ? s - 360 : 0;
        if (s <= 179)
            return s * (s + 1) / 2 + lon_v + 1;
        else if (s <= 359)
            return 16290 + (s - 180) * 180 + 180 - lat_v;
        return 48690 + n * (719 - s) / 2 + 180 - lat_v;
    endfunction

    // works out the characters one pair produces and queues them
    function automatic void encode_pair(input coord_pair_t p, input logic [OFFSET_W-1:0] offset,
                                        input logic formatted);
        int unsigned lat_w;
        int unsigned lon_w;
        int unsigned lat_f;
        int unsigned lon_f;
        int unsigned div;
        logic [63:0] place;
        logic [63:0] point;
        logic [DIGIT_W-1:0] rev[0:15];
        logic [CHAR_W-1:0]  out_chars[0:15];
        logic [7:0] sym;
        int len;
        int use_len;
        int n;
        int i;
        grid_char_t c;

        // out-of-range fields saturate
        lat_w = 32'((p.lat_whole > LAT_WHOLE_MAX) ? LAT_WHOLE_MAX : p.lat_whole);
        lon_w = 32'((p.lon_whole > LON_WHOLE_MAX) ? LON_WHOLE_MAX : p.lon_whole);
        lat_f = 32'((p.lat_fraction > FRAC_MAX) ? FRAC_MAX : p.lat_fraction);
        lon_f = 32'((p.lon_fraction > FRAC_MAX) ? FRAC_MAX : p.lon_fraction);

        point = 64'(pair_combination(lon_w * 2 + 32'(p.lon_negative),
                                     lat_w * 2 + 32'(p.lat_negative)))
                * 64'd10000000000;
        // fraction digits interleaved, longitude digit ahead of latitude digit
        place = 64'd1000000000;
        div = 10000;
        for (i = 0; i < 5; i++) begin
            point += place * 64'((lon_f / div) % 10);
            place /= 10;
            point += place * 64'((lat_f / div) % 10);
            place /= 10;
            div /= 10;
        end
        point += 64'(offset);

        // base-27 digits, least significant first
        len = 0;
        if (point == 0) begin
            rev[0] = '0;
            len = 1;
        end
        while (point != 0 && len < 16) begin
            rev[len] = DIGIT_W'(point % 27);
            point /= 27;
            len++;
        end

        n = 0;
        if (formatted) begin
            out_chars[n++] = CHAR_HASH;
            use_len = (len > 11) ? 11 : len;
            for (i = 0; i < use_len; i++) begin
                sym = GRID_DIGITS[8*(26 - rev[len-1-i]) +: 8];
                out_chars[n++] = sym[CHAR_W-1:0];
                if (i == 3 || i == 7)
                    out_chars[n++] = CHAR_DASH;
            end
        end else begin
            for (i = 0; i < len && i < 14; i++) begin
                sym = GRID_DIGITS[8*(26 - rev[len-1-i]) +: 8];
                out_chars[n++] = sym[CHAR_W-1:0];
            end
        end

        for (i = 0; i < n; i++) begin
            c.code_char = out_chars[i];
            c.last_char = (i == n - 1);
            expected_chars.push_back(c);
        end
    endfunction

    function automatic coord_pair_t make_pair(input int ln, input int lw, input int lf,
                                              input int on, input int ow, input int of);
        coord_pair_t p;
        p.lat_negative = 1'(ln);
        p.lat_whole    = LAT_WHOLE_W'(lw);
        p.lat_fraction = FRAC_W'(lf);
        p.lon_negative = 1'(on);
        p.lon_whole    = LON_WHOLE_W'(ow);
        p.lon_fraction = FRAC_W'(of);
        return p;
    endfunction

    // mostly legal coordinates, about one in five drawn over the full field widths
    function automatic coord_pair_t random_pair();
        coord_pair_t p;
        logic wide;
        wide = ($urandom_range(0, 4) == 0);
        p.lat_negative = 1'($urandom_range(0, 1));
        p.lon_negative = 1'($urandom_range(0, 1));
        p.lat_whole    = LAT_WHOLE_W'(wide ? $urandom_range(0, 127) : $urandom_range(0, 89));
        p.lon_whole    = LON_WHOLE_W'(wide ? $urandom_range(0, 255) : $urandom_range(0, 179));
        p.lat_fraction = FRAC_W'(wide ? $urandom_range(0, 131071) : $urandom_range(0, 99999));
        p.lon_fraction = FRAC_W'(wide ? $urandom_range(0, 131071) : $urandom_range(0, 99999));
        return p;
    endfunction

    // register write, one cycle of write enable
    task automatic write_reg(input logic idx, input logic [OFFSET_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // sender holds off until every queued pair is taken and every character has come
    task automatic wait_drained();
        while (pending_pairs.size() != 0 || start || expected_chars.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic queue_random(input int count);
        repeat (count) pending_pairs.push_back(random_pair());
    endtask

    // driver: presents one pair per transaction, inputs change on the falling edge
    always @(negedge clk) begin : drive_pairs
        coord_pair_t nxt;
        if (rst_n && (!start || took_pair)) begin
            if (gap_left != 0) begin
                // sender idle burst
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (pending_pairs.size() != 0) begin
                nxt = pending_pairs.pop_front();
                start        <= 1'b1;
                lat_negative <= nxt.lat_negative;
                lat_whole    <= nxt.lat_whole;
                lat_fraction <= nxt.lat_fraction;
                lon_negative <= nxt.lon_negative;
                lon_whole    <= nxt.lon_whole;
                lon_fraction <= nxt.lon_fraction;
                // the gap follows once this pair is taken
                if (sender_idles && $urandom_range(0, 3) == 0)
                    gap_left <= $urandom_range(1, 10);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: predicts on each taken pair, checks each strobed character, runs the watchdog
    always @(posedge clk or negedge rst_n) begin : check_chars
        grid_char_t want;
        if (!rst_n) begin
            took_pair      <= 1'b0;
            offset_copy    <= OFFSET_RESET;
            formatted_copy <= 1'b1;
            quiet_cycles   <= 0;
        end else begin
            took_pair <= start && !busy;

            if (cfg_write) begin
                if (cfg_index == CFG_POINT_OFFSET)
                    offset_copy <= cfg_data;
                else
                    formatted_copy <= cfg_data[0];
            end

            if (char_valid) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected character: code_char %0d last_char %0b",
                           code_char, last_char);
                    fail_count++;
                end else begin
                    want = expected_chars.pop_front();
                    chars_checked++;
                    if (code_char !== want.code_char) begin
                        $error("code_char mismatch: expected %0d (%s) got %0d",
                               want.code_char, want.code_char, code_char);
                        fail_count++;
                    end
                    if (last_char !== want.last_char) begin
                        $error("last_char mismatch: expected %0b got %0b",
                               want.last_char, last_char);
                        fail_count++;
                    end
                end
            end

            // pair transaction: queue its code under the current register copies
            if (start && !busy) begin
                encode_pair('{lat_negative, lat_whole, lat_fraction,
                              lon_negative, lon_whole, lon_fraction},
                            offset_copy, formatted_copy);
                pairs_taken++;
            end

            if ((start && !busy) || char_valid || cfg_write) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("geo_grid_code_encoder verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // stimulus: phases of register settings, each one drained before the next write
    initial begin : run_phases
        logic [63:0] rand_offset;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: hash form with the default offset, directed pairs
        settings_run++;
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(1, 89, 99999, 1, 179, 99999));
        // saturation of every field, all bits set
        pending_pairs.push_back(make_pair(1, 127, 131071, 1, 255, 131071));
        pending_pairs.push_back(make_pair(1, 127, 0, 1, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 99999, 0, 255, 0));
        pending_pairs.push_back(make_pair(0, 45, 100000, 0, 90, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 131071));
        // edges of the triangular band
        pending_pairs.push_back(make_pair(0, 0, 0, 1, 89, 12345));
        pending_pairs.push_back(make_pair(1, 89, 0, 0, 0, 0));
        // edges of the linear band
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 90, 0));
        pending_pairs.push_back(make_pair(1, 89, 54321, 1, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 1, 179, 0));
        pending_pairs.push_back(make_pair(1, 89, 0, 0, 90, 0));
        // falling triangular band, lowest and near top sums
        pending_pairs.push_back(make_pair(1, 0, 0, 1, 179, 0));
        pending_pairs.push_back(make_pair(0, 89, 0, 0, 91, 0));
        pending_pairs.push_back(make_pair(0, 89, 77777, 1, 179, 11111));
        // digit interleave patterns
        pending_pairs.push_back(make_pair(0, 12, 13579, 0, 34, 24680));
        pending_pairs.push_back(make_pair(0, 1, 1, 0, 1, 1));
        pending_pairs.push_back(make_pair(1, 0, 99999, 0, 0, 99999));
        pending_pairs.push_back(make_pair(0, 44, 50505, 1, 100, 90909));
        wait_drained();

        // zero offset, hash form: shortest codes, only the first dash on 7 symbols
        write_reg(CFG_POINT_OFFSET, '0);
        settings_run++;
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(1, 89, 99999, 1, 179, 99999));
        queue_random(32);
        wait_drained();

        // zero offset, plain form
        write_reg(CFG_FORMATTED, 1'b0);
        settings_run++;
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(1, 89, 99999, 1, 179, 99999));
        queue_random(30);
        wait_drained();

        // all-ones offset: 12 symbol codes, plain then hash form with truncation
        write_reg(CFG_POINT_OFFSET, {OFFSET_W{1'b1}});
        settings_run++;
        pending_pairs.push_back(make_pair(1, 89, 99999, 1, 179, 99999));
        queue_random(12);
        wait_drained();
        write_reg(CFG_FORMATTED, 1'b1);
        settings_run++;
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(1, 89, 99999, 1, 179, 99999));
        queue_random(25);
        wait_drained();

        // large offset, plain form
        write_reg(CFG_POINT_OFFSET, OFFSET_W'(64'd4900000000000000));
        write_reg(CFG_FORMATTED, 1'b0);
        settings_run++;
        pending_pairs.push_back(make_pair(1, 89, 99999, 1, 179, 99999));
        queue_random(25);
        wait_drained();

        // last part: random offset and form, sender never idles
        rand_offset = {$urandom, $urandom};
        write_reg(CFG_POINT_OFFSET, rand_offset[OFFSET_W-1:0]);
        write_reg(CFG_FORMATTED, OFFSET_W'(1'($urandom_range(0, 1))));
        settings_run++;
        sender_idles = 1'b0;
        queue_random(35);
        wait_drained();

        // watch for stray characters after the last expected one
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("run covered %0d coordinate pairs and %0d code characters", pairs_taken,
                 chars_checked);
        $display("over %0d register settings, both output forms and offsets from zero to full",
                 settings_run);
        if (fail_count == 0 && expected_chars.size() == 0) begin
            $display("geo_grid_code_encoder verification clean");
        end else begin
            if (expected_chars.size() != 0)
                $error("%0d expected characters never arrived", expected_chars.size());
            $display("geo_grid_code_encoder verification failed");
        end
        $finish;
    end

endmodule
